// ===== rtl/lfs_pkg.sv =====
// Shared types and constants for the LED strip frame serializer.
package lfs_pkg;

  // Action codes carried by an input beat
  typedef enum logic [1:0] {
    ACT_WR_MASK = 2'd0,
    ACT_WR_LED  = 2'd1,
    ACT_RD_MASK = 2'd2,
    ACT_RD_LED  = 2'd3
  } action_t;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_BRIGHTNESS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLOR      = 1'b1;
  localparam int unsigned CFG_DATA_W = 24;

  localparam logic [4:0]  BRIGHTNESS_RST = 5'd10;
  localparam logic [23:0] COLOR_RST      = 24'd100;

  // Frame byte constants
  localparam logic [7:0] HDR_BASE  = 8'hE0;
  localparam logic [7:0] START_BYTE = 8'h00;
  localparam logic [7:0] END_BYTE   = 8'hFF;

  // Which part of the frame a byte belongs to
  typedef enum logic [1:0] {
    FK_START = 2'd0,
    FK_LED   = 2'd1,
    FK_END   = 2'd2
  } frame_kind_t;

  // Byte selector control
  typedef struct packed {
    frame_kind_t kind;
    logic [1:0]  pos;
    logic        lit;
  } byte_sel_t;

  typedef struct packed {
    action_t    action;
    logic [2:0] led_select;
    logic [7:0] value;
  } in_item_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic [7:0] read_value;
    logic       is_reply;
    logic       last;
  } out_item_t;

endpackage

// ===== rtl/lfs_byte_gen.sv =====
// Frame byte selector shared by every byte position of the frame.
module lfs_byte_gen (
  input  lfs_pkg::byte_sel_t sel,
  input  logic [4:0]         brightness,
  input  logic [23:0]        color,
  output logic [7:0]         frame_byte
);
  import lfs_pkg::*;

  // Pick the byte for the current frame slot
  always_comb begin
    frame_byte = START_BYTE;
    unique case (sel.kind)
      FK_START: frame_byte = START_BYTE;
      FK_END:   frame_byte = END_BYTE;
      FK_LED: begin
        unique case (sel.pos)
          2'd0: frame_byte = sel.lit ? (HDR_BASE | {3'b000, brightness}) : HDR_BASE;
          2'd1: frame_byte = sel.lit ? color[23:16] : 8'h00;
          2'd2: frame_byte = sel.lit ? color[15:8]  : 8'h00;
          2'd3: frame_byte = sel.lit ? color[7:0]   : 8'h00;
          default: frame_byte = 8'h00;
        endcase
      end
      default: frame_byte = START_BYTE;
    endcase
  end

endmodule

// ===== rtl/led_strip_frame_serializer_top.sv =====
// Top level of the LED strip frame serializer: state, sequencer and ports.
//
// Each write beat (mask or single LED) updates the stored mask and LED bytes
// and then sends one frame of 4*NUM_LEDS+8 bytes (40 with eight LEDs): four
// zero bytes, four bytes per LED, four 0xFF bytes, the last one flagged. A
// byte sequencer walks the frame through one shared byte selector, one result
// beat per cycle while out_stall is low; in_stall stays high until the frame
// has gone out. A read beat returns one reply beat and the block can take
// the next item once that reply is not held by out_stall. Configuration
// writes are taken at any time and are meant to land only while the block
// is idle.
module led_strip_frame_serializer_top #(
  parameter int unsigned NUM_LEDS = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  lfs_pkg::in_item_t                   in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output lfs_pkg::out_item_t                  out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [lfs_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [lfs_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import lfs_pkg::*;

  localparam int unsigned LED_W = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
  localparam logic [LED_W-1:0] LED_LAST = LED_W'(NUM_LEDS - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_START,
    S_LED,
    S_END
  } state_t;

  state_t           state_r, state_nxt;
  logic [1:0]       pos_r, pos_nxt;
  logic [LED_W-1:0] led_r, led_nxt;
  logic [7:0]       mask_r, mask_nxt;
  logic [7:0]       vals_r [NUM_LEDS];
  logic [7:0]       vals_nxt [NUM_LEDS];
  logic [4:0]       brightness_r;
  logic [23:0]      color_r;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_data_r, out_data_nxt;

  logic             out_free;
  logic             in_accept;
  logic             sel_in_range;
  logic [7:0]       led_rd;
  logic [2:0]       lit_idx;
  byte_sel_t        bsel;
  logic [7:0]       gen_byte;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE) || !out_free;
  assign in_accept = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign cfg_ready = 1'b1;

  assign sel_in_range = {1'b0, in_data.led_select} < 4'(NUM_LEDS);

  // Look up the stored byte of the selected LED
  always_comb begin
    led_rd = 8'h00;
    for (int i = 0; i < NUM_LEDS; i++) begin
      if (in_data.led_select == 3'(i)) begin
        led_rd = vals_r[i];
      end
    end
  end

  // Drive the shared byte selector from the sequencer position
  assign lit_idx = 3'd7 - 3'(led_r);
  always_comb begin
    bsel.pos = pos_r;
    bsel.lit = mask_r[lit_idx];
    unique case (state_r)
      S_LED:   bsel.kind = FK_LED;
      S_END:   bsel.kind = FK_END;
      default: bsel.kind = FK_START;
    endcase
  end

  lfs_byte_gen u_byte_gen (
    .sel        (bsel),
    .brightness (brightness_r),
    .color      (color_r),
    .frame_byte (gen_byte)
  );

  // Sequencer next state, stored state update and output register
  always_comb begin
    state_nxt     = state_r;
    pos_nxt       = pos_r;
    led_nxt       = led_r;
    mask_nxt      = mask_r;
    vals_nxt      = vals_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && out_stall;

    unique case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          unique case (in_data.action)
            ACT_RD_MASK: begin
              out_valid_nxt = 1'b1;
              out_data_nxt  = '{frame_byte: 8'h00, read_value: mask_r,
                                is_reply: 1'b1, last: 1'b1};
            end
            ACT_RD_LED: begin
              out_valid_nxt = 1'b1;
              out_data_nxt  = '{frame_byte: 8'h00,
                                read_value: sel_in_range ? led_rd : 8'h00,
                                is_reply: 1'b1, last: 1'b1};
            end
            ACT_WR_MASK: begin
              mask_nxt  = in_data.value;
              state_nxt = S_START;
              pos_nxt   = 2'd0;
            end
            ACT_WR_LED: begin
              if (sel_in_range) begin
                for (int i = 0; i < NUM_LEDS; i++) begin
                  if (in_data.led_select == 3'(i)) begin
                    vals_nxt[i] = in_data.value;
                  end
                end
                mask_nxt[in_data.led_select] = (in_data.value != 8'h00);
              end
              state_nxt = S_START;
              pos_nxt   = 2'd0;
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_START, S_LED, S_END: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{frame_byte: gen_byte, read_value: 8'h00,
                            is_reply: 1'b0,
                            last: (state_r == S_END) && (pos_r == 2'd3)};
          pos_nxt = pos_r + 2'd1;
          if (pos_r == 2'd3) begin
            priority if (state_r == S_START) begin
              state_nxt = S_LED;
              led_nxt   = '0;
            end else if (state_r == S_LED) begin
              if (led_r == LED_LAST) begin
                state_nxt = S_END;
              end else begin
                led_nxt = led_r + 1'b1;
              end
            end else begin
              state_nxt = S_IDLE;
            end
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pos_r       <= 2'd0;
      led_r       <= '0;
      mask_r      <= 8'h00;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_LEDS; i++) begin
        vals_r[i] <= 8'h00;
      end
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      led_r       <= led_nxt;
      mask_r      <= mask_nxt;
      out_valid_r <= out_valid_nxt;
      vals_r      <= vals_nxt;
    end
  end

  // Hold the output payload
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  // Take configuration beats
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      brightness_r <= BRIGHTNESS_RST;
      color_r      <= COLOR_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_BRIGHTNESS: brightness_r <= cfg_data[4:0];
        CFG_COLOR:      color_r      <= cfg_data[23:0];
        default:        brightness_r <= brightness_r;
      endcase
    end
  end

endmodule

// ===== tb/lfs_frame_checker.sv =====
// Checker for the LED strip frame serializer: models the strip and compares result beats.
module lfs_frame_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  lfs_pkg::in_item_t             in_data,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  lfs_pkg::out_item_t            out_data,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [lfs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lfs_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                            mismatches,
  output int                            owed_count
);
  import lfs_pkg::*;

  localparam int LEDS       = 8;
  localparam int FRAME_LEN  = 4 * LEDS + 8;
  localparam int PRINT_CAP  = 40;

  // Model copy of the strip state and the look registers
  logic [7:0]  lit_mask;
  logic [7:0]  led_bytes [LEDS];
  logic [4:0]  glow;
  logic [23:0] tint;

  // Result beats still owed by the block, oldest first
  out_item_t   owed_beats [$];
  out_item_t   want;
  int          beat_no;

  // Print one line per mismatch (up to a cap) and count it
  task automatic report_mismatch(input string what, input int got, input int exp_val);
    if (mismatches < PRINT_CAP)
      $display("[%0t] result beat %0d %s: got 0x%0h, want 0x%0h",
               $time, beat_no, what, got, exp_val);
    mismatches++;
  endtask

  // Apply one accepted command to the model and queue the beats it causes
  task automatic encode_item(input in_item_t it);
    out_item_t  r;
    logic [7:0] frame [FRAME_LEN];
    int         n;
    int         k;
    r = '0;
    n = 0;
    case (it.action)
      ACT_RD_MASK: begin
        r.read_value = lit_mask;
        r.is_reply   = 1'b1;
        r.last       = 1'b1;
        owed_beats.push_back(r);
      end
      ACT_RD_LED: begin
        r.read_value = (it.led_select < LEDS) ? led_bytes[it.led_select] : 8'h00;
        r.is_reply   = 1'b1;
        r.last       = 1'b1;
        owed_beats.push_back(r);
      end
      default: begin
        // Update the mask, then build the whole frame
        if (it.action == ACT_WR_MASK) begin
          lit_mask = it.value;
        end else if (it.led_select < LEDS) begin
          led_bytes[it.led_select] = it.value;
          lit_mask[it.led_select]  = (it.value != 8'h00);
        end
        for (k = 0; k < 4; k++) begin
          frame[n] = START_BYTE;
          n++;
        end
        for (k = 0; k < LEDS; k++) begin
          // LED k shows mask bit 7-k
          if (lit_mask[7-k]) begin
            frame[n]   = HDR_BASE | {3'b000, glow};
            frame[n+1] = tint[23:16];
            frame[n+2] = tint[15:8];
            frame[n+3] = tint[7:0];
          end else begin
            frame[n]   = HDR_BASE;
            frame[n+1] = 8'h00;
            frame[n+2] = 8'h00;
            frame[n+3] = 8'h00;
          end
          n += 4;
        end
        for (k = 0; k < 4; k++) begin
          frame[n] = END_BYTE;
          n++;
        end
        for (k = 0; k < n; k++) begin
          r            = '0;
          r.frame_byte = frame[k];
          r.last       = (k == n - 1);
          owed_beats.push_back(r);
        end
      end
    endcase
  endtask

  // Watch all three channels at each rising edge
  always @(posedge clk) begin
    if (!rst_n) begin
      lit_mask = '0;
      foreach (led_bytes[j]) led_bytes[j] = '0;
      glow = BRIGHTNESS_RST;
      tint = COLOR_RST;
      owed_beats.delete();
      mismatches = 0;
      beat_no    = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_BRIGHTNESS)
          glow = cfg_data[4:0];
        else if (cfg_index == CFG_COLOR)
          tint = cfg_data[23:0];
      end

      if (in_valid && !in_stall)
        encode_item(in_data);

      // Compare each result beat with the oldest owed one
      if (out_valid && !out_stall) begin
        if (owed_beats.size() == 0) begin
          report_mismatch("arrived with nothing owed, frame_byte", out_data.frame_byte, 0);
        end else begin
          want = owed_beats.pop_front();
          if (out_data.frame_byte !== want.frame_byte)
            report_mismatch("frame_byte", out_data.frame_byte, want.frame_byte);
          if (out_data.read_value !== want.read_value)
            report_mismatch("read_value", out_data.read_value, want.read_value);
          if (out_data.is_reply !== want.is_reply)
            report_mismatch("is_reply", out_data.is_reply, want.is_reply);
          if (out_data.last !== want.last)
            report_mismatch("last", out_data.last, want.last);
        end
        beat_no++;
      end
    end
    owed_count = owed_beats.size();
  end

endmodule

// ===== tb/testbench.sv =====
// Testbench top for the LED strip frame serializer: clock, reset, stimulus and verdict.
module testbench;
  import lfs_pkg::*;

  localparam int PHASES        = 6;
  localparam int PHASE_ITEMS   = 40;
  localparam int CYCLE_LIMIT   = 300000;
  localparam int SETTLE_CYCLES = 60;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_stall;
  out_item_t             out_data;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int mismatches;
  int owed_count;
  int cycles = 0;
  bit calm   = 1'b0;

  led_strip_frame_serializer_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  lfs_frame_checker u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .mismatches (mismatches),
    .owed_count (owed_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("led_strip_frame_serializer_top verification failed");
      $finish;
    end
  end

  // Roughly one cycle in four idles, except during the calm phase
  function automatic bit take_break();
    return !calm && ($urandom_range(99) < 26);
  endfunction

  // Stall the result channel at random
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      out_stall = take_break();
    end
  end

  // Offer one command beat and hold it until accepted
  task automatic send_cmd(input action_t act, input logic [2:0] sel, input logic [7:0] val);
    in_item_t it;
    it.action     = act;
    it.led_select = sel;
    it.value      = val;
    @(negedge clk);
    while (take_break()) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Drop valid and hold off until every owed beat has come back
  task automatic wait_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (owed_count != 0) @(negedge clk);
  endtask

  // Write brightness (junk in the unused upper bits) and color while idle
  task automatic set_look(input logic [4:0] lvl, input logic [23:0] rgb);
    wait_drained();
    cfg_valid = 1'b1;
    cfg_index = CFG_BRIGHTNESS;
    cfg_data  = {19'($urandom()), lvl};
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_index = CFG_COLOR;
    cfg_data  = rgb;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  initial begin
    int         p;
    int         k;
    int         pick;
    logic [7:0] val;

    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: reset look, reads of the cleared state, mask and LED corner cases
    send_cmd(ACT_RD_MASK, 3'd0, 8'h00);
    send_cmd(ACT_RD_LED,  3'd0, 8'h00);
    send_cmd(ACT_RD_LED,  3'd7, 8'hFF);
    send_cmd(ACT_WR_MASK, 3'd0, 8'hFF);
    send_cmd(ACT_WR_MASK, 3'd7, 8'h00);
    send_cmd(ACT_WR_MASK, 3'd5, 8'hA5);
    send_cmd(ACT_RD_MASK, 3'd2, 8'h5A);
    send_cmd(ACT_WR_LED,  3'd0, 8'hFF);
    send_cmd(ACT_WR_LED,  3'd7, 8'h01);
    send_cmd(ACT_RD_LED,  3'd0, 8'h00);
    send_cmd(ACT_RD_LED,  3'd7, 8'h00);
    send_cmd(ACT_RD_MASK, 3'd0, 8'h00);
    // A zero byte clears the LED's mask bit
    send_cmd(ACT_WR_LED,  3'd0, 8'h00);
    send_cmd(ACT_RD_LED,  3'd0, 8'h00);
    send_cmd(ACT_RD_MASK, 3'd0, 8'h00);

    set_look(5'd31, 24'hFFFFFF);
    send_cmd(ACT_WR_MASK, 3'd1, 8'hFF);
    send_cmd(ACT_WR_LED,  3'd3, 8'h80);

    set_look(5'd0, 24'h000000);
    send_cmd(ACT_WR_MASK, 3'd6, 8'hFF);
    send_cmd(ACT_WR_LED,  3'd4, 8'h00);
    send_cmd(ACT_RD_LED,  3'd4, 8'h00);
    send_cmd(ACT_RD_LED,  3'd3, 8'h00);

    // Random phases, each with its own look; one phase runs without idling
    for (p = 0; p < PHASES; p++) begin
      case (p)
        0:       set_look(5'd31, 24'hFFFFFF);
        1:       set_look(5'd0, 24'h000000);
        default: set_look(5'($urandom_range(31)), 24'($urandom_range(24'hFFFFFF)));
      endcase
      calm = (p == 3);
      for (k = 0; k < PHASE_ITEMS; k++) begin
        pick = $urandom_range(99);
        if (pick < 15)
          val = 8'h00;
        else if (pick < 25)
          val = 8'hFF;
        else
          val = 8'($urandom_range(255));
        send_cmd(action_t'($urandom_range(3)), 3'($urandom_range(7)), val);
      end
    end

    // Drain, then give stray beats a chance to show up
    calm = 1'b0;
    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatches == 0)
      $display("led_strip_frame_serializer_top verification clean");
    else
      $display("led_strip_frame_serializer_top verification failed");
    $finish;
  end

endmodule
